[rtl/core/tlfd_pkg.sv]
// ----------------------------------------------------------------------------
// tlfd_pkg: shared types and constants of the tagged length frame deframer
// Header geometry, frame tag, result kind codes and field types.
// ----------------------------------------------------------------------------
package tlfd_pkg;

  // Header: 4 tag bytes, 4 length bytes, 1 check byte
  localparam int HEADER_BYTES = 9;
  localparam int WIN_DEPTH    = HEADER_BYTES - 1;
  localparam int FILL_W       = $clog2(WIN_DEPTH + 1);

  // Tag as a 32-bit word, first wire byte in the low bits
  localparam logic [31:0] FRAME_TAG = 32'h1adf_5fed;

  // Result kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef logic [7:0]        byte_t;
  typedef logic [31:0]       len_t;
  typedef logic [FILL_W-1:0] fill_t;

endpackage

[rtl/core/tlfd_if.sv]
// ----------------------------------------------------------------------------
// tlfd_if: channel interfaces of the tagged length frame deframer
// Byte input channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface tlfd_in_if;
  logic            valid;
  logic            ready;
  tlfd_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tlfd_out_if;
  logic            valid;
  logic            ready;
  logic            kind;
  tlfd_pkg::byte_t data_byte;
  tlfd_pkg::len_t  payload_length;
  logic            last;

  modport source (output valid, output kind, output data_byte, output payload_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input payload_length,
                  input last, output ready);
endinterface

[rtl/core/tagged_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// tagged_length_frame_deframer: byte stream frame sync and deframer
// Hunts for a tagged, length-prefixed, XOR-checked header and forwards payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw stream byte per request. While hunting, bytes are
//   dropped into an 8-byte window; a byte that completes a valid header
//   (tag ED 5F DF 1A, big-endian length, XOR check byte) yields one start
//   result on out_ch with the length. The next length bytes are forwarded as
//   data results, the final one with last set. A zero-length frame gives a
//   single start result with last set. The window is emptied on every header.
//   Each result is registered and valid the cycle after its byte is taken.
//   Throughput: one byte per cycle; the window compare, XOR and counter update
//   sit between the state registers and the single output register.
//   Stall: in_ch.ready drops only while the output register holds a result
//   that out_ch has not taken; hunted bytes that give no result still need it.
//   Reset (rst_n low, synchronous): hunting, empty window, no result pending.
// ----------------------------------------------------------------------------
module tagged_length_frame_deframer (
  input  logic      clk,
  input  logic      rst_n,
  tlfd_in_if.sink   in_ch,
  tlfd_out_if.source out_ch
);

  // State
  tlfd_pkg::byte_t win_r   [tlfd_pkg::WIN_DEPTH];
  tlfd_pkg::byte_t win_nxt [tlfd_pkg::WIN_DEPTH];
  tlfd_pkg::fill_t fill_r, fill_nxt;
  logic            in_payload_r, in_payload_nxt;
  tlfd_pkg::len_t  remaining_r, remaining_nxt;
  tlfd_pkg::len_t  frame_len_r, frame_len_nxt;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  tlfd_pkg::byte_t out_data_r, out_data_nxt;
  tlfd_pkg::len_t  out_len_r, out_len_nxt;
  logic            out_last_r, out_last_nxt;

  logic            in_acc;
  logic            res_vld;
  tlfd_pkg::byte_t win_xor;
  logic            hdr_hit;
  tlfd_pkg::len_t  win_len;

  // Accept whenever the output register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Header check against the window and the arriving byte
  always_comb begin
    win_xor = '0;
    for (int i = 0; i < tlfd_pkg::WIN_DEPTH; i++) begin
      win_xor = win_xor ^ win_r[i];
    end
  end

  assign hdr_hit = (fill_r == tlfd_pkg::fill_t'(tlfd_pkg::WIN_DEPTH))
                && ({win_r[3], win_r[2], win_r[1], win_r[0]} == tlfd_pkg::FRAME_TAG)
                && (win_xor == in_ch.in_byte);
  assign win_len = {win_r[4], win_r[5], win_r[6], win_r[7]};

  // Next state and result
  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    remaining_nxt  = remaining_r;
    frame_len_nxt  = frame_len_r;
    res_vld        = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    if (in_acc) begin
      if (in_payload_r) begin
        // Forward payload byte, count down
        res_vld      = 1'b1;
        out_kind_nxt = tlfd_pkg::KIND_DATA;
        out_data_nxt = in_ch.in_byte;
        out_len_nxt  = frame_len_r;
        out_last_nxt = (remaining_r <= 32'd1);
        if (remaining_r <= 32'd1) begin
          remaining_nxt  = '0;
          in_payload_nxt = 1'b0;
        end else begin
          remaining_nxt = remaining_r - 32'd1;
        end
      end else if (hdr_hit) begin
        // Start frame, empty the window
        res_vld        = 1'b1;
        out_kind_nxt   = tlfd_pkg::KIND_START;
        out_data_nxt   = '0;
        out_len_nxt    = win_len;
        out_last_nxt   = (win_len == '0);
        frame_len_nxt  = win_len;
        remaining_nxt  = win_len;
        in_payload_nxt = (win_len != '0);
        fill_nxt       = '0;
        for (int i = 0; i < tlfd_pkg::WIN_DEPTH; i++) begin
          win_nxt[i] = '0;
        end
      end else begin
        // Drop hunted byte into the window, oldest falls out
        for (int i = 0; i < tlfd_pkg::WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[tlfd_pkg::WIN_DEPTH-1] = in_ch.in_byte;
        if (fill_r != tlfd_pkg::fill_t'(tlfd_pkg::WIN_DEPTH)) begin
          fill_nxt = fill_r + tlfd_pkg::fill_t'(1);
        end
      end
    end

    // Load on a new result, else drain when taken
    if (res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      remaining_r  <= '0;
      frame_len_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      in_payload_r <= in_payload_nxt;
      remaining_r  <= remaining_nxt;
      frame_len_r  <= frame_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Window and result payload
  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.data_byte      = out_data_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.last           = out_last_r;

`ifndef ASSERT_OFF
  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (remaining_r != '0))
    else $error("payload state with nothing left to forward");

  a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (fill_r == '0))
    else $error("window filled during payload");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= tlfd_pkg::fill_t'(tlfd_pkg::WIN_DEPTH))
    else $error("window fill beyond depth");

  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_payload_r) |=> (out_valid_r && (out_kind_r == tlfd_pkg::KIND_DATA)))
    else $error("payload byte gave no data result");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_payload_r && (remaining_r == 32'd1)) |=> (!in_payload_r && out_last_r))
    else $error("final payload byte did not end the frame");
`endif

endmodule

[tb/tb_tagged_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// tb_tagged_length_frame_deframer: self-checking bench for the frame deframer
// Feeds the byte stream and checks every result against a local deframer model.
// A short table of directed bytes comes first: zero-length and short frames,
// a missed header position, and tag bytes inside a payload. Random traffic
// follows: clean frames with junk between them, corrupted or truncated
// headers, and near-miss noise. It ends in a truncated maximum-length frame.
// Both sides idle at random, the output side holds off once for a long
// stretch, and the input side pauses once until the output has drained.
// ----------------------------------------------------------------------------
module tb_tagged_length_frame_deframer;

  localparam int IDLE_PCT     = 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int STREAM_BYTES = 1250;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NO_CORRUPT   = tlfd_pkg::HEADER_BYTES;

  typedef struct packed {
    logic            kind;
    tlfd_pkg::byte_t data_byte;
    tlfd_pkg::len_t  payload_length;
    logic            last;
  } frame_res_t;

  typedef struct packed {
    tlfd_pkg::byte_t b;
    logic            typed;
    frame_res_t      res;
  } dir_row_t;

  localparam frame_res_t NO_RES = '0;

  // Directed stream: zero-length frame from reset, one junk byte, then a
  // 5-byte frame whose first check position misses and whose payload holds
  // the first three tag bytes, then one hunted byte
  localparam dir_row_t DIR_TAB [0:24] = '{
    '{8'hED, 1'b0, NO_RES}, '{8'h5F, 1'b0, NO_RES}, '{8'hDF, 1'b0, NO_RES},
    '{8'h1A, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h77, 1'b1, '{tlfd_pkg::KIND_START, 8'h00, 32'd0, 1'b1}},
    '{8'h00, 1'b0, NO_RES},
    '{8'hED, 1'b0, NO_RES}, '{8'h5F, 1'b0, NO_RES}, '{8'hDF, 1'b0, NO_RES},
    '{8'h1A, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h05, 1'b0, NO_RES},
    '{8'h72, 1'b1, '{tlfd_pkg::KIND_START, 8'h00, 32'd5, 1'b0}},
    '{8'hFF, 1'b0, NO_RES}, '{8'hED, 1'b0, NO_RES}, '{8'h5F, 1'b0, NO_RES},
    '{8'hDF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h1A, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  tlfd_in_if  in_ch ();
  tlfd_out_if out_ch ();

  tagged_length_frame_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Deframer state as the bench sees it
  tlfd_pkg::byte_t hunt_win [tlfd_pkg::WIN_DEPTH];
  int              hunt_fill;
  bit              in_frame;
  tlfd_pkg::len_t  left_bytes;
  tlfd_pkg::len_t  cur_len;

  frame_res_t pending_results [$];
  int         mismatch_cnt;
  int         sent_cnt;
  int         start_cnt;
  int         data_cnt;
  int         cycle_cnt;
  bit         hold_req;
  bit         steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the deframer by one byte; return 1 with the result if one is due
  function automatic bit deframe_byte(input tlfd_pkg::byte_t b, output frame_res_t r);
    tlfd_pkg::byte_t chk;
    tlfd_pkg::len_t  tag;
    tlfd_pkg::len_t  len;
    bit              done;
    int              i;
    r = '0;
    // Payload bytes bypass the window entirely
    if (in_frame) begin
      done = (left_bytes <= 1);
      r.kind           = tlfd_pkg::KIND_DATA;
      r.data_byte      = b;
      r.payload_length = cur_len;
      r.last           = done;
      if (done) begin
        left_bytes = '0;
        in_frame   = 1'b0;
      end else begin
        left_bytes = left_bytes - 1;
      end
      return 1'b1;
    end
    tag = {hunt_win[3], hunt_win[2], hunt_win[1], hunt_win[0]};
    chk = '0;
    for (i = 0; i < tlfd_pkg::WIN_DEPTH; i++) chk = chk ^ hunt_win[i];
    // Full window, tag and check byte agree: header found, empty the window
    if (hunt_fill == tlfd_pkg::WIN_DEPTH && tag == tlfd_pkg::FRAME_TAG && chk == b) begin
      len = {hunt_win[4], hunt_win[5], hunt_win[6], hunt_win[7]};
      for (i = 0; i < tlfd_pkg::WIN_DEPTH; i++) hunt_win[i] = '0;
      hunt_fill  = 0;
      cur_len    = len;
      left_bytes = len;
      in_frame   = (len != 0);
      r.kind           = tlfd_pkg::KIND_START;
      r.payload_length = len;
      r.last           = (len == 0);
      return 1'b1;
    end
    // Drop the byte into the window, oldest byte falls out once full
    if (hunt_fill < tlfd_pkg::WIN_DEPTH) begin
      hunt_win[hunt_fill] = b;
      hunt_fill++;
    end else begin
      for (i = 0; i < tlfd_pkg::WIN_DEPTH - 1; i++) hunt_win[i] = hunt_win[i + 1];
      hunt_win[tlfd_pkg::WIN_DEPTH - 1] = b;
    end
    return 1'b0;
  endfunction

  function automatic void compare_field(input string name, input tlfd_pkg::len_t want,
                                        input tlfd_pkg::len_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Offer one byte, idling at random first; return at the accepting edge
  task automatic send_byte(input tlfd_pkg::byte_t b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent_cnt++;
  endtask

  task automatic feed_byte(input tlfd_pkg::byte_t b);
    frame_res_t r;
    send_byte(b);
    if (deframe_byte(b, r)) pending_results.push_back(r);
  endtask

  // Hold the input side until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Send hdr_bytes of a header (one byte optionally corrupted), then pay_bytes
  task automatic send_frame(input tlfd_pkg::len_t len, input int bad_idx, input int hdr_bytes,
                            input int pay_bytes);
    tlfd_pkg::byte_t hdr [tlfd_pkg::HEADER_BYTES];
    int              i;
    hdr[0] = tlfd_pkg::FRAME_TAG[7:0];
    hdr[1] = tlfd_pkg::FRAME_TAG[15:8];
    hdr[2] = tlfd_pkg::FRAME_TAG[23:16];
    hdr[3] = tlfd_pkg::FRAME_TAG[31:24];
    hdr[4] = len[31:24];
    hdr[5] = len[23:16];
    hdr[6] = len[15:8];
    hdr[7] = len[7:0];
    hdr[8] = '0;
    for (i = 0; i < tlfd_pkg::WIN_DEPTH; i++) hdr[8] = hdr[8] ^ hdr[i];
    if (bad_idx < tlfd_pkg::HEADER_BYTES) begin
      hdr[bad_idx] = hdr[bad_idx] ^ tlfd_pkg::byte_t'($urandom_range(1, 255));
    end
    for (i = 0; i < hdr_bytes; i++) feed_byte(hdr[i]);
    for (i = 0; i < pay_bytes; i++) feed_byte(tlfd_pkg::byte_t'($urandom));
  endtask

  // Noise leans toward tag bytes so near-miss headers show up
  function automatic tlfd_pkg::byte_t noise_byte();
    case ($urandom_range(0, 7))
      0: return tlfd_pkg::FRAME_TAG[7:0];
      1: return tlfd_pkg::FRAME_TAG[15:8];
      2: return tlfd_pkg::FRAME_TAG[23:16];
      3: return tlfd_pkg::FRAME_TAG[31:24];
      default: return tlfd_pkg::byte_t'($urandom);
    endcase
  endfunction

  function automatic tlfd_pkg::len_t pick_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return tlfd_pkg::len_t'($urandom_range(0, 8));
    if (pick < 95) return tlfd_pkg::len_t'($urandom_range(9, 40));
    return tlfd_pkg::len_t'($urandom_range(100, 300));
  endfunction

  // Output side: random idles, one long counted hold-off on request
  initial begin
    int held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          held     = 0;
        end
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check each taken result against the oldest prediction
  initial begin
    frame_res_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d data 0x%0h length 0x%0h last %0d",
                   $time, out_ch.kind, out_ch.data_byte, out_ch.payload_length, out_ch.last);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", tlfd_pkg::len_t'(want.kind), tlfd_pkg::len_t'(out_ch.kind));
          compare_field("data_byte", tlfd_pkg::len_t'(want.data_byte),
                        tlfd_pkg::len_t'(out_ch.data_byte));
          compare_field("payload_length", want.payload_length, out_ch.payload_length);
          compare_field("last", tlfd_pkg::len_t'(want.last), tlfd_pkg::len_t'(out_ch.last));
          if (want.kind == tlfd_pkg::KIND_START) start_cnt++;
          else data_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    frame_res_t     r;
    tlfd_pkg::len_t len;
    int             frame_no;
    int             pick;
    int             k;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    hold_req      = 1'b0;
    steady        = 1'b0;
    mismatch_cnt  = 0;
    sent_cnt      = 0;
    start_cnt     = 0;
    data_cnt      = 0;
    for (k = 0; k < tlfd_pkg::WIN_DEPTH; k++) hunt_win[k] = '0;
    hunt_fill  = 0;
    in_frame   = 1'b0;
    left_bytes = '0;
    cur_len    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; typed rows carry their own expected result
    for (k = 0; k < 25; k++) begin
      send_byte(DIR_TAB[k].b);
      if (deframe_byte(DIR_TAB[k].b, r) && !DIR_TAB[k].typed) pending_results.push_back(r);
      if (DIR_TAB[k].typed) pending_results.push_back(DIR_TAB[k].res);
    end

    // Random traffic, mostly clean frames
    frame_no = 0;
    while (sent_cnt < STREAM_BYTES) begin
      frame_no++;
      if (frame_no == 40) wait_drained();
      steady = (frame_no >= 24 && frame_no < 36);
      pick   = $urandom_range(0, 99);
      if (frame_no == 20) begin
        // Stall the output while a long frame keeps the input busy
        hold_req = 1'b1;
        send_frame(tlfd_pkg::len_t'(60), NO_CORRUPT, tlfd_pkg::HEADER_BYTES, 60);
      end else if (pick < 65) begin
        repeat ($urandom_range(0, 2)) feed_byte(noise_byte());
        len = pick_length();
        send_frame(len, NO_CORRUPT, tlfd_pkg::HEADER_BYTES, int'(len));
      end else if (pick < 80) begin
        send_frame(pick_length(), $urandom_range(0, tlfd_pkg::HEADER_BYTES - 1),
                   tlfd_pkg::HEADER_BYTES, 0);
      end else if (pick < 90) begin
        send_frame(pick_length(), NO_CORRUPT, $urandom_range(1, tlfd_pkg::WIN_DEPTH), 0);
      end else begin
        repeat ($urandom_range(1, 6)) feed_byte(noise_byte());
      end
    end
    steady = 1'b0;

    // Largest length last: only its first few payload bytes are sent
    send_frame(32'hFFFF_FFFF, NO_CORRUPT, tlfd_pkg::HEADER_BYTES, 6);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d stream bytes; checked %0d frame starts and %0d payload bytes.",
             sent_cnt, start_cnt, data_cnt);
    $display("Covered corrupted and truncated headers, noise, a long output hold and a drain.");
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tlfd_pkg.sv
rtl/core/tlfd_if.sv
rtl/core/tagged_length_frame_deframer.sv
tb/tb_tagged_length_frame_deframer.sv
